// ===== src/crc32_packet_framer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the CRC-32 packet framer
// Each macro expands to a labeled concurrent assertion, or to nothing when
// ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef CRC32_PACKET_FRAMER_MACROS_SVH
`define CRC32_PACKET_FRAMER_MACROS_SVH

`ifndef ASSERT_OFF
// check that a property holds at every clock edge outside reset
`define FRAMER_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
// check that a condition never holds outside reset
`define FRAMER_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define FRAMER_ASSERT(name, clk, rst, prop)
`define FRAMER_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

// ===== src/crc32pf_pkg.sv =====
// ---------------------------------------------------------------------------
// CRC-32 packet framer package
// Shared types, register codes, limits and the byte-wide CRC-32 update.
// ---------------------------------------------------------------------------
package crc32pf_pkg;

   localparam int MAX_PAYLOAD = 1024;
   localparam int LenWidth = 11;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 11;
   localparam logic [LenWidth-1:0] MaxPayloadLen = LenWidth'(MAX_PAYLOAD);
   localparam logic [31:0] CrcPoly = 32'hEDB88320;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PREAMBLE_FIRST  = 3'd0,
      CSR_PREAMBLE_SECOND = 3'd1,
      CSR_SOURCE_ADDR     = 3'd2,
      CSR_DEST_ADDR       = 3'd3,
      CSR_PAYLOAD_LENGTH  = 3'd4
   } csr_index_type;

   // position of a word within the results of one payload byte
   typedef enum logic [3:0] {
      SLOT_PRE_FIRST  = 4'd0,
      SLOT_PRE_SECOND = 4'd1,
      SLOT_SOURCE     = 4'd2,
      SLOT_DEST       = 4'd3,
      SLOT_DATA       = 4'd4,
      SLOT_CRC0       = 4'd5,
      SLOT_CRC1       = 4'd6,
      SLOT_CRC2       = 4'd7,
      SLOT_CRC3       = 4'd8
   } slot_type;

   typedef struct packed {
      logic [7:0]          preamble_first;
      logic [7:0]          preamble_second;
      logic [7:0]          source_addr;
      logic [7:0]          dest_addr;
      logic [LenWidth-1:0] payload_length;
   } cfg_type;

   // everything the emitter needs to send the words of one payload byte
   typedef struct packed {
      logic        frame_start;
      logic        frame_end;
      logic [7:0]  data_byte;
      logic [31:0] crc;
   } rec_type;

   // update an inverted CRC register with one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] r;
      r = ~acc;
      r[7:0] = r[7:0] ^ b;
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
      return ~r;
   endfunction

endpackage

// ===== src/crc32pf_req_if.sv =====
// ---------------------------------------------------------------------------
// Payload request channel
// Valid/ready channel carrying one payload byte per word.
// ---------------------------------------------------------------------------
interface crc32pf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

// ===== src/crc32pf_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Framed response channel
// Valid/ready channel carrying one framed output byte and its flags per word.
// ---------------------------------------------------------------------------
interface crc32pf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_last;

   modport source (output valid, output out_byte, output run_last, output frame_last,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input frame_last,
                 output ready);
endinterface

// ===== src/crc32pf_csr.sv =====
// ---------------------------------------------------------------------------
// Framer configuration registers
// Holds the header bytes and the payload length written over the CSR port.
// ---------------------------------------------------------------------------
module crc32pf_csr (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic [crc32pf_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [crc32pf_pkg::CsrDataWidth-1:0]      csr_wdata,
   output crc32pf_pkg::cfg_type                      cfg
);
   import crc32pf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PREAMBLE_FIRST:  cfg_in.preamble_first  = csr_wdata[7:0];
            CSR_PREAMBLE_SECOND: cfg_in.preamble_second = csr_wdata[7:0];
            CSR_SOURCE_ADDR:     cfg_in.source_addr     = csr_wdata[7:0];
            CSR_DEST_ADDR:       cfg_in.dest_addr       = csr_wdata[7:0];
            CSR_PAYLOAD_LENGTH:  cfg_in.payload_length  = csr_wdata[LenWidth-1:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{preamble_first: 8'd0, preamble_second: 8'd0, source_addr: 8'd0,
                     dest_addr: 8'd0, payload_length: LenWidth'(64)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/crc32pf_core.sv =====
// ---------------------------------------------------------------------------
// Framer position and CRC core
// Tracks the byte position in the frame and the running CRC, and builds the
// emit record for each accepted payload byte.
// ---------------------------------------------------------------------------
module crc32pf_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [7:0]                           data_byte,
   input  logic [crc32pf_pkg::LenWidth-1:0]     payload_length,
   output crc32pf_pkg::rec_type                 rec,
   output logic [crc32pf_pkg::LenWidth-1:0]     frame_pos
);
   import crc32pf_pkg::*;

   logic [LenWidth-1:0] pos_ff;
   logic [LenWidth-1:0] pos_in;
   logic [31:0]         crc_ff;
   logic [31:0]         crc_in;
   logic                frame_start;
   logic [31:0]         crc_base;
   logic [31:0]         crc_new;
   logic [LenWidth-1:0] pos_inc;
   logic [LenWidth-1:0] len_eff;
   logic                frame_end;

   always_comb begin
      frame_start = (pos_ff == '0);
      crc_base    = frame_start ? '0 : crc_ff;
      crc_new     = crc_byte(crc_base, data_byte);
      pos_inc     = pos_ff + LenWidth'(1);
      // clamp length to the supported range
      if (payload_length == '0) begin
         len_eff = LenWidth'(1);
      end else if (payload_length > MaxPayloadLen) begin
         len_eff = MaxPayloadLen;
      end else begin
         len_eff = payload_length;
      end
      frame_end = (pos_inc >= len_eff);

      rec.frame_start = frame_start;
      rec.frame_end   = frame_end;
      rec.data_byte   = data_byte;
      rec.crc         = crc_new;

      pos_in = pos_ff;
      crc_in = crc_ff;
      if (accept) begin
         if (frame_end) begin
            pos_in = '0;
            crc_in = '0;
         end else begin
            pos_in = pos_inc;
            crc_in = crc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   assign frame_pos = pos_ff;

endmodule

// ===== src/crc32pf_emit.sv =====
// ---------------------------------------------------------------------------
// Framer output sequencer
// Holds one emit record; sends header (frame start), data, CRC (frame end).
// ---------------------------------------------------------------------------
module crc32pf_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  crc32pf_pkg::rec_type   rec,
   input  crc32pf_pkg::cfg_type   cfg,
   output logic                   load_ready,
   crc32pf_rsp_if.source          rsp_if
);
   import crc32pf_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   slot_type slot_ff;
   slot_type slot_in;
   rec_type  rec_ff;
   rec_type  rec_in;
   slot_type last_slot;
   logic     is_last;

   assign last_slot  = rec_ff.frame_end ? SLOT_CRC3 : SLOT_DATA;
   assign is_last    = (slot_ff == last_slot);
   assign load_ready = !valid_ff || (rsp_if.ready && is_last);

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      rec_in   = rec_ff;
      if (load) begin
         valid_in = 1'b1;
         rec_in   = rec;
         slot_in  = rec.frame_start ? SLOT_PRE_FIRST : SLOT_DATA;
      end else if (valid_ff && rsp_if.ready) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            slot_in = slot_type'(slot_ff + 4'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      rec_ff  <= rec_in;
   end

   always_comb begin
      case (slot_ff)
         SLOT_PRE_FIRST:  rsp_if.out_byte = cfg.preamble_first;
         SLOT_PRE_SECOND: rsp_if.out_byte = cfg.preamble_second;
         SLOT_SOURCE:     rsp_if.out_byte = cfg.source_addr;
         SLOT_DEST:       rsp_if.out_byte = cfg.dest_addr;
         SLOT_DATA:       rsp_if.out_byte = rec_ff.data_byte;
         SLOT_CRC0:       rsp_if.out_byte = rec_ff.crc[7:0];
         SLOT_CRC1:       rsp_if.out_byte = rec_ff.crc[15:8];
         SLOT_CRC2:       rsp_if.out_byte = rec_ff.crc[23:16];
         SLOT_CRC3:       rsp_if.out_byte = rec_ff.crc[31:24];
         default:         rsp_if.out_byte = '0;
      endcase
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.run_last   = is_last;
   assign rsp_if.frame_last = (slot_ff == SLOT_CRC3);

endmodule

// ===== src/crc32_packet_framer.sv =====
// ---------------------------------------------------------------------------
// CRC-32 packet framer
// Wraps a payload byte stream into frames: two preamble bytes, source and
// destination address, payload_length payload bytes, then the IEEE CRC-32 of
// the payload, least significant byte first.
//
// Usage:
//   req_if carries one payload byte per word, rsp_if one framed byte per word
//   with run_last (last word caused by that payload byte) and frame_last
//   (final CRC byte of the frame). Write the csr_ registers only while idle.
//   The first word for a payload byte appears in the cycle after it is
//   accepted. The single output register drains one word per cycle while
//   rsp_if.ready is high, and a payload byte causes one word mid-frame, five
//   on the first byte of a frame (header), five on the last (CRC) and nine
//   when the frame is one byte long. A new payload byte is taken in the same
//   cycle the last word of the previous one leaves.
//   Reset (synchronous) sets the CSR, position and CRC registers to defaults,
//   empties the output register and starts a new frame. If rsp_if.ready is low
//   the current word holds and req_if.ready drops until its last word is taken.
// ---------------------------------------------------------------------------
`include "crc32_packet_framer_macros.svh"

module crc32_packet_framer (
   input  logic                                  clock,
   input  logic                                  reset,
   crc32pf_req_if.sink                           req_if,
   crc32pf_rsp_if.source                         rsp_if,
   input  logic                                  csr_we,
   input  logic [crc32pf_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [crc32pf_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import crc32pf_pkg::*;

   cfg_type             cfg;
   rec_type             core_rec;
   logic [LenWidth-1:0] frame_pos;
   logic                load_ready;
   logic                req_accept;

   // accept a payload byte whenever the output register can take its record
   assign req_if.ready = load_ready;
   assign req_accept   = req_if.valid && load_ready;

   // configuration registers
   crc32pf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // frame position, running CRC and record build
   crc32pf_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .data_byte      (req_if.data_byte),
      .payload_length (cfg.payload_length),
      .rec            (core_rec),
      .frame_pos      (frame_pos)
   );

   // output register and word sequencing
   crc32pf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .rec        (core_rec),
      .cfg        (cfg),
      .load_ready (load_ready),
      .rsp_if     (rsp_if)
   );

   // a new record only replaces a held one while its last word leaves
   `FRAMER_ASSERT(a_no_overwrite, clock, reset, (req_accept && rsp_if.valid) |-> (rsp_if.ready && rsp_if.run_last))
   // a frame-ending byte restarts the frame position
   `FRAMER_ASSERT(a_end_restarts, clock, reset, (req_accept && core_rec.frame_end) |=> (frame_pos == '0))
   // the final CRC byte is always the last word of its payload byte
   `FRAMER_ASSERT(a_flast_rlast, clock, reset, (rsp_if.valid && rsp_if.frame_last) |-> rsp_if.run_last)
   // the frame position stays below the maximum payload length
   `FRAMER_ASSERT_NEVER(a_pos_range, clock, reset, frame_pos >= MaxPayloadLen)

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the CRC-32 packet framer
// Drives payload bytes with random gaps and response stalls, and predicts
// every framed word: header, payload, and the CRC-32 of the payload, LSB
// first. Each accepted word is checked in order against the prediction.
// The tests cover register defaults and masking, one-byte frames, zero and
// oversize lengths, unused register indexes, a length change mid-frame,
// back-pressure and random frame phases.
// ---------------------------------------------------------------------------
module tb_top;
   import crc32pf_pkg::*;

   // register indexes above the last defined one; writes there are ignored
   localparam logic [CsrIndexWidth-1:0] CsrSpareFirst = 3'd5;
   localparam int NumPhases = 12;
   localparam int WordsPerPhase = 16;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_last;
   } framed_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   crc32pf_req_if req_bus ();
   crc32pf_rsp_if rsp_bus ();

   crc32_packet_framer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the block: configuration, frame position and running CRC
   cfg_type             shadow_cfg;
   logic [LenWidth-1:0] frame_pos;
   logic [31:0]         frame_crc;

   framed_word_type expected_words[$];
   int  mismatch_count = 0;
   bit  sender_idle_on = 1'b1;
   bit  receiver_idle_on = 1'b1;
   bit  req_offered = 1'b0;
   int  hold_off_len = 0;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 200) begin
         $display("mismatch at %0t ns: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // Gap length in cycles: zero for zero_pct percent of calls, else mostly
   // short, now and then long.
   function automatic int pick_gap(input int zero_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // Advance the inverted CRC register by one byte, one data bit at a time.
   function automatic logic [31:0] crc32_advance(input logic [31:0] inv_crc,
                                                 input logic [7:0] b);
      logic [31:0] lfsr;
      logic        fb;
      lfsr = ~inv_crc;
      for (int i = 0; i < 8; i++) begin
         fb = lfsr[0] ^ b[i];
         lfsr = lfsr >> 1;
         if (fb) lfsr = lfsr ^ CrcPoly;
      end
      return ~lfsr;
   endfunction

   function automatic void push_word(input logic [7:0] b, input logic flast);
      framed_word_type w;
      w.out_byte = b;
      w.run_last = 1'b0;
      w.frame_last = flast;
      expected_words.push_back(w);
   endfunction

   // Work out every framed word that one accepted payload byte causes.
   function automatic void predict_framed_words(input logic [7:0] b);
      logic [LenWidth-1:0] limit;
      framed_word_type     tail;
      limit = shadow_cfg.payload_length;
      // zero acts as one, anything past the maximum acts as the maximum
      if (limit == '0) limit = LenWidth'(1);
      if (limit > MaxPayloadLen) limit = MaxPayloadLen;
      if (frame_pos == '0) begin
         frame_crc = '0;
         push_word(shadow_cfg.preamble_first, 1'b0);
         push_word(shadow_cfg.preamble_second, 1'b0);
         push_word(shadow_cfg.source_addr, 1'b0);
         push_word(shadow_cfg.dest_addr, 1'b0);
      end
      push_word(b, 1'b0);
      frame_crc = crc32_advance(frame_crc, b);
      frame_pos = frame_pos + LenWidth'(1);
      // the frame ends where the count reaches or passes the length in force
      if (frame_pos >= limit) begin
         push_word(frame_crc[7:0], 1'b0);
         push_word(frame_crc[15:8], 1'b0);
         push_word(frame_crc[23:16], 1'b0);
         push_word(frame_crc[31:24], 1'b1);
         frame_pos = '0;
         frame_crc = '0;
      end
      // flag the last word of this byte
      tail = expected_words.pop_back();
      tail.run_last = 1'b1;
      expected_words.push_back(tail);
   endfunction

   // Write one register; call only with the block idle.
   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PREAMBLE_FIRST:  shadow_cfg.preamble_first = val[7:0];
         CSR_PREAMBLE_SECOND: shadow_cfg.preamble_second = val[7:0];
         CSR_SOURCE_ADDR:     shadow_cfg.source_addr = val[7:0];
         CSR_DEST_ADDR:       shadow_cfg.dest_addr = val[7:0];
         CSR_PAYLOAD_LENGTH:  shadow_cfg.payload_length = val[LenWidth-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offer one payload byte, hold it until taken, then predict its words.
   // Valid stays high on return so back-to-back bytes need no gap.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_idle_on ? pick_gap(65) : 0;
      if (gap > 0) begin
         if (req_offered) begin
            req_bus.valid <= 1'b0;
            req_offered = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_offered = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      predict_framed_words(b);
   endtask

   // Drop valid and hold until every expected word has arrived.
   task automatic drain_results();
      if (req_offered) begin
         req_bus.valid <= 1'b0;
         req_offered = 1'b0;
      end
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic set_header(input logic [CsrDataWidth-1:0] pf,
                             input logic [CsrDataWidth-1:0] ps,
                             input logic [CsrDataWidth-1:0] sa,
                             input logic [CsrDataWidth-1:0] da);
      write_csr(CSR_PREAMBLE_FIRST, pf);
      write_csr(CSR_PREAMBLE_SECOND, ps);
      write_csr(CSR_SOURCE_ADDR, sa);
      write_csr(CSR_DEST_ADDR, da);
   endtask

   // -------------------------------------------------------------------------
   // Response side: stall at random, or hold off for a long stretch on order.
   // -------------------------------------------------------------------------
   initial begin : response_sink
      int stall;
      int hold;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_off_len != 0) begin
            // hold ready low for the ordered number of cycles
            hold = hold_off_len;
            hold_off_len = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold - 1) @(posedge clock);
         end else begin
            stall = receiver_idle_on ? pick_gap(70) : 0;
            if (stall == 0) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               repeat (stall - 1) @(posedge clock);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Compare each accepted word with the oldest expectation.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_words
      framed_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("word 0x%02h with nothing expected", rsp_bus.out_byte));
         end else begin
            want = expected_words.pop_front();
            if (rsp_bus.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h",
                                         rsp_bus.out_byte, want.out_byte));
            if (rsp_bus.run_last !== want.run_last)
               report_mismatch($sformatf("run_last %b, want %b",
                                         rsp_bus.run_last, want.run_last));
            if (rsp_bus.frame_last !== want.frame_last)
               report_mismatch($sformatf("frame_last %b, want %b",
                                         rsp_bus.frame_last, want.frame_last));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Run one default frame of 64 bytes with no register written.
   task automatic test_reset_defaults();
      for (int i = 0; i < 64; i++) send_byte(8'($urandom_range(0, 255)));
      drain_results();
   endtask

   // One-byte frames: header plus data plus CRC on every byte. Write data
   // with upper bits set to check the 8-bit masking, then try length zero.
   task automatic test_one_byte_frames();
      set_header(11'h7A5, 11'h05A, 11'h0FF, 11'h000);
      write_csr(CSR_PAYLOAD_LENGTH, 11'd1);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h01);
      drain_results();
      // length zero acts as one
      write_csr(CSR_PAYLOAD_LENGTH, 11'd0);
      send_byte(8'h7F);
      send_byte(8'hFE);
      drain_results();
   endtask

   // Writes to unused indexes must change nothing.
   task automatic test_unknown_index();
      for (int i = CsrSpareFirst; i < (1 << CsrIndexWidth); i++) begin
         write_csr(CsrIndexWidth'(i), 11'h7FF);
         write_csr(CsrIndexWidth'(i), CsrDataWidth'($urandom_range(0, 2047)));
      end
      send_byte(8'h3C);
      send_byte(8'hC3);
      send_byte(8'($urandom_range(0, 255)));
      drain_results();
   endtask

   // Start a frame at the maximum length, shrink the length below the count
   // already taken, and check the frame ends on the next byte.
   task automatic test_length_change_midframe();
      set_header(11'h0FF, 11'h0FF, 11'h700, 11'h7FF);
      write_csr(CSR_PAYLOAD_LENGTH, MaxPayloadLen);
      send_byte(8'h00);
      send_byte(8'hFF);
      for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)));
      drain_results();
      write_csr(CSR_PAYLOAD_LENGTH, 11'd4);
      send_byte(8'hA5);
      drain_results();
      write_csr(CSR_PAYLOAD_LENGTH, 11'd3);
      for (int i = 0; i < 3; i++) send_byte(8'($urandom_range(0, 255)));
      drain_results();
   endtask

   // Length above the maximum: a long run of bytes must not end the frame
   // early. Stream with no idling on either side; the frame stays open and
   // the next length write closes it.
   task automatic test_oversize_length();
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      write_csr(CSR_PAYLOAD_LENGTH, 11'h7FF);
      for (int i = 0; i < 64; i++) send_byte(8'($urandom_range(0, 255)));
      drain_results();
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   // Hold the response side off for a long stretch while bytes keep coming,
   // so the block fills and drops its input ready.
   task automatic test_backpressure();
      write_csr(CSR_PAYLOAD_LENGTH, 11'd8);
      hold_off_len = 300;
      for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)));
      drain_results();
   endtask

   // Random phases: new settings between phases, random bytes within, with
   // a pause until empty in some phases and a long hold-off in one.
   task automatic test_random_phases();
      int r;
      int pause_at;
      logic [CsrDataWidth-1:0] len;
      for (int phase = 0; phase < NumPhases; phase++) begin
         sender_idle_on = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 0) begin
            set_header(11'h000, 11'h000, 11'h000, 11'h000);
            write_csr(CSR_PAYLOAD_LENGTH, 11'd1);
         end else if (phase == 1) begin
            set_header(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
            write_csr(CSR_PAYLOAD_LENGTH, 11'd2);
         end else begin
            if ($urandom_range(0, 9) < 6)
               write_csr(CSR_PREAMBLE_FIRST, CsrDataWidth'($urandom_range(0, 2047)));
            if ($urandom_range(0, 9) < 6)
               write_csr(CSR_PREAMBLE_SECOND, CsrDataWidth'($urandom_range(0, 2047)));
            if ($urandom_range(0, 9) < 6)
               write_csr(CSR_SOURCE_ADDR, CsrDataWidth'($urandom_range(0, 2047)));
            if ($urandom_range(0, 9) < 6)
               write_csr(CSR_DEST_ADDR, CsrDataWidth'($urandom_range(0, 2047)));
            if ($urandom_range(0, 9) == 0)
               write_csr(CsrIndexWidth'($urandom_range(CsrSpareFirst, 7)),
                         CsrDataWidth'($urandom_range(0, 2047)));
            // mostly short frames; now and then zero, one or oversize
            r = $urandom_range(0, 9);
            if (r == 0) len = '0;
            else if (r == 1) len = 11'd1;
            else if (r == 2) len = CsrDataWidth'($urandom_range(MAX_PAYLOAD + 1, 2047));
            else len = CsrDataWidth'($urandom_range(2, 24));
            write_csr(CSR_PAYLOAD_LENGTH, len);
         end
         pause_at = (phase % 3 == 1) ? $urandom_range(1, WordsPerPhase - 1) : -1;
         for (int i = 0; i < WordsPerPhase; i++) begin
            if (i == pause_at) drain_results();
            if (phase == 5 && i == 10) hold_off_len = 200;
            r = $urandom_range(0, 19);
            if (r == 0) send_byte(8'h00);
            else if (r == 1) send_byte(8'hFF);
            else send_byte(8'($urandom_range(0, 255)));
         end
         drain_results();
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      // shadow starts at the reset values
      shadow_cfg.preamble_first = '0;
      shadow_cfg.preamble_second = '0;
      shadow_cfg.source_addr = '0;
      shadow_cfg.dest_addr = '0;
      shadow_cfg.payload_length = LenWidth'(64);
      frame_pos = '0;
      frame_crc = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_one_byte_frames();
      test_unknown_index();
      test_length_change_midframe();
      test_oversize_length();
      test_backpressure();
      test_random_phases();

      // let any stray word show up before the verdict
      repeat (20) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
